@@ rtl/core/mhls_pkg.sv @@
// ----------------------------------------------------------------------------
// mhls_pkg
// Shared types and constants for the header line splitter: byte codes,
// result kinds, limit sizes and the structs passed between modules.
// ----------------------------------------------------------------------------
package mhls_pkg;

  // Storage sizes that bound the programmable limits
  localparam int LineBufferBytes = 4096;
  localparam int HeaderSlots     = 128;

  localparam logic [11:0] LenCapMax =
    (LineBufferBytes - 1 > 4095) ? 12'd4095 : 12'(LineBufferBytes - 1);
  localparam logic [7:0]  HdrCapMax = 8'(HeaderSlots);

  // Register reset values
  localparam logic [11:0] MaxLineLengthReset = 12'd4095;
  localparam logic [7:0]  MaxHeadersReset    = 8'd128;

  // Configuration register indexes
  localparam logic [0:0] RegMaxLineLength = 1'b0;
  localparam logic [0:0] RegMaxHeaders    = 1'b1;

  // Character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  // Byte classification
  typedef enum logic [2:0] {
    KIND_NAME      = 3'd0,
    KIND_VALUE     = 3'd1,
    KIND_SEP       = 3'd2,
    KIND_END_HDR   = 3'd3,
    KIND_END_INPUT = 3'd4,
    KIND_TOO_LONG  = 3'd5,
    KIND_BODY      = 3'd6
  } kind_t;

  // Effective limits handed to the parser
  typedef struct packed {
    logic [11:0] len_cap;
    logic [7:0]  hdr_cap;
  } mhls_cfg_t;

  // One result
  typedef struct packed {
    logic        header_overflow;
    logic        line_dropped;
    logic        header_complete;
    logic [7:0]  header_index;
    kind_t       kind;
    logic [7:0]  out_byte;
  } mhls_result_t;

endpackage

@@ rtl/core/mime_header_line_splitter_core.sv @@
// Path: an input byte passes the input register, then the result register.
// Throughput: 1 byte per cycle unless m_axis stalls; the parser classifies
//   each byte combinationally between the input and result registers.
// Reset: synchronous rst empties both registers, returns the parser to line
//   start with zero length and count, and sets the limits to 4095 and 128.
// ----------------------------------------------------------------------------
// mime_header_line_splitter_core
// Streaming header line splitter: classes each byte of MIME-style header
// text and flags completed, dropped and overflowing header lines.
// ----------------------------------------------------------------------------
module mime_header_line_splitter_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [11:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_block
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [15:8] header_index,
                                      // [16] header_complete, [17] line_dropped,
                                      // [18] header_overflow, [23:19] zero
  output logic [2:0]  m_axis_tuser    // [2:0] kind
);

  logic [11:0] max_line_length;
  logic [7:0]  max_headers;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;

  logic        out_free;
  logic        step;

  mhls_pkg::mhls_cfg_t    cfg;
  mhls_pkg::mhls_result_t result;

  // Hold the limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= mhls_pkg::MaxLineLengthReset;
      max_headers     <= mhls_pkg::MaxHeadersReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mhls_pkg::RegMaxLineLength: max_line_length <= cfg_data;
        mhls_pkg::RegMaxHeaders:    max_headers     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Clamp the limits to the storage sizes
  always_comb begin
    cfg.len_cap = (max_line_length > mhls_pkg::LenCapMax) ? mhls_pkg::LenCapMax
                                                          : max_line_length;
    cfg.hdr_cap = (max_headers > mhls_pkg::HdrCapMax) ? mhls_pkg::HdrCapMax
                                                      : max_headers;
  end

  // Handshake: advance when the result register is free or drains
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  mhls_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (in_byte),
    .start_block (in_start),
    .cfg         (cfg),
    .result      (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {5'd0, result.header_overflow, result.line_dropped,
                       result.header_complete, result.header_index, result.out_byte};
      m_axis_tuser <= result.kind;
    end
  end

endmodule

@@ rtl/core/mhls_parse.sv @@
// ----------------------------------------------------------------------------
// mhls_parse
// Per-byte parser: holds phase, line length and header count, and classes
// the current byte combinationally. State advances on each step.
// ----------------------------------------------------------------------------
module mhls_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  start_block,
  input  mhls_pkg::mhls_cfg_t   cfg,
  output mhls_pkg::mhls_result_t result
);

  typedef enum logic [2:0] {
    PH_LINE_START = 3'd0,
    PH_NAME       = 3'd1,
    PH_SKIP_WS    = 3'd2,
    PH_VALUE      = 3'd3,
    PH_AFTER_CR   = 3'd4,
    PH_START_CR   = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [11:0] line_length;
  logic [11:0] line_length_next;
  logic [7:0]  header_count;
  logic [7:0]  header_count_next;

  phase_t      ph;
  logic [11:0] len_cur;
  logic [7:0]  cnt_cur;
  logic        handled;
  logic        term;

  // Classify the byte and work out the next state
  always_comb begin
    ph      = start_block ? PH_LINE_START : phase;
    len_cur = start_block ? 12'd0 : line_length;
    cnt_cur = start_block ? 8'd0 : header_count;
    handled = 1'b0;
    term    = (data_byte == mhls_pkg::ChNul) || (data_byte == mhls_pkg::ChCr);

    phase_next        = ph;
    line_length_next  = len_cur;
    header_count_next = cnt_cur;

    result.out_byte        = data_byte;
    result.kind            = mhls_pkg::KIND_BODY;
    result.header_index    = cnt_cur;
    result.header_complete = 1'b0;
    result.line_dropped    = 1'b0;
    result.header_overflow = 1'b0;

    // Resolve the byte after a CR
    if (ph == PH_AFTER_CR) begin
      if (data_byte == mhls_pkg::ChLf) begin
        result.kind = mhls_pkg::KIND_SEP;
        phase_next  = PH_LINE_START;
        handled     = 1'b1;
      end else begin
        ph = PH_LINE_START;
      end
    end else if (ph == PH_START_CR) begin
      if (data_byte == mhls_pkg::ChLf) begin
        result.kind = mhls_pkg::KIND_END_HDR;
        phase_next  = PH_DONE;
        handled     = 1'b1;
      end else begin
        result.line_dropped = 1'b1;
        ph = PH_LINE_START;
      end
    end

    if (!handled) begin
      if (ph > PH_VALUE) begin
        // After an end everything is body
        result.kind = mhls_pkg::KIND_BODY;
        phase_next  = PH_DONE;
      end else if (term) begin
        // Close the line
        if (ph == PH_SKIP_WS || ph == PH_VALUE) begin
          if (cnt_cur < cfg.hdr_cap) begin
            result.header_complete = 1'b1;
            header_count_next      = cnt_cur + 8'd1;
          end else begin
            result.header_overflow = 1'b1;
          end
        end else if (ph == PH_NAME) begin
          result.line_dropped = 1'b1;
        end
        line_length_next = 12'd0;
        if (data_byte == mhls_pkg::ChNul) begin
          result.kind = mhls_pkg::KIND_END_INPUT;
          phase_next  = PH_DONE;
        end else begin
          result.kind = mhls_pkg::KIND_SEP;
          phase_next  = (ph == PH_LINE_START) ? PH_START_CR : PH_AFTER_CR;
        end
      end else if (len_cur >= cfg.len_cap) begin
        // Abort on an overlong line
        result.kind = mhls_pkg::KIND_TOO_LONG;
        phase_next  = PH_DONE;
      end else begin
        line_length_next = len_cur + 12'd1;
        if (ph == PH_LINE_START || ph == PH_NAME) begin
          if (data_byte == mhls_pkg::ChColon) begin
            result.kind = mhls_pkg::KIND_SEP;
            phase_next  = PH_SKIP_WS;
          end else begin
            result.kind = mhls_pkg::KIND_NAME;
            phase_next  = PH_NAME;
          end
        end else if (ph == PH_SKIP_WS) begin
          if (data_byte == mhls_pkg::ChSpace || data_byte == mhls_pkg::ChTab) begin
            result.kind = mhls_pkg::KIND_SEP;
            phase_next  = PH_SKIP_WS;
          end else begin
            result.kind = mhls_pkg::KIND_VALUE;
            phase_next  = PH_VALUE;
          end
        end else begin
          result.kind = mhls_pkg::KIND_VALUE;
          phase_next  = PH_VALUE;
        end
      end
    end
  end

  // Advance the parser state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LINE_START;
      line_length  <= 12'd0;
      header_count <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      line_length  <= line_length_next;
      header_count <= header_count_next;
    end
  end

endmodule

@@ rtl/core/mhls_checker.sv @@
// ----------------------------------------------------------------------------
// mhls_checker
// Port-level checks on the header line splitter result stream.
// ----------------------------------------------------------------------------
module mhls_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Drop the output after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Raise at most one line flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $countones(m_axis_tdata[18:16]) <= 1)
    else $error("several line flags at once");

  // Close a counted or overflowing line only on CR or NUL
  a_close_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[16] || m_axis_tdata[18]) |->
      (m_axis_tuser == mhls_pkg::KIND_SEP || m_axis_tuser == mhls_pkg::KIND_END_INPUT))
    else $error("header closed on wrong kind");

endmodule

bind mime_header_line_splitter_core mhls_checker u_mhls_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/mhls_stream_checker.sv @@
// ----------------------------------------------------------------------------
// mhls_stream_checker
// Watches the configuration port and both streams of the header line
// splitter, classifies every accepted input byte with its own parser model
// and compares each result against the oldest outstanding classification.
// ----------------------------------------------------------------------------
module mhls_stream_checker
  import mhls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [11:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_block
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] out_byte, [15:8] header_index,
                                      // [16] header_complete, [17] line_dropped,
                                      // [18] header_overflow, [23:19] zero
  input  logic [2:0]  m_axis_tuser,   // [2:0] kind
  output int          pending_results,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_LINE_START,
    ST_NAME,
    ST_SKIP_WS,
    ST_VALUE,
    ST_AFTER_CR,
    ST_START_CR,
    ST_DONE
  } parse_st_t;

  // Model of the parser and its limits
  parse_st_t    parse_st;
  logic [11:0]  line_len;
  logic [7:0]   hdr_count;
  logic [11:0]  len_limit;
  logic [7:0]   hdr_limit;
  mhls_result_t classified_q[$];
  int           errors;

  initial begin
    pending_results = 0;
    fail_count      = 0;
    errors          = 0;
  end

  always @(posedge clk) begin : track
    mhls_result_t got;
    mhls_result_t want;
    parse_st_t    st;
    logic         handled;
    logic [11:0]  len_cap;
    logic [7:0]   hdr_cap;

    if (rst) begin
      parse_st  = ST_LINE_START;
      line_len  = '0;
      hdr_count = '0;
      len_limit = MaxLineLengthReset;
      hdr_limit = MaxHeadersReset;
      classified_q.delete();
    end else begin
      // Compare the result against the oldest classification
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[18:8], m_axis_tuser, m_axis_tdata[7:0]};
        if (classified_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result byte %02h kind %0d", $realtime,
                     got.out_byte, got.kind);
          errors++;
        end else begin
          want = classified_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display({"%0t: mismatch exp byte %02h kind %0d idx %0d c%0b d%0b o%0b",
                        " | got byte %02h kind %0d idx %0d c%0b d%0b o%0b"},
                       $realtime, want.out_byte, want.kind, want.header_index,
                       want.header_complete, want.line_dropped, want.header_overflow,
                       got.out_byte, got.kind, got.header_index,
                       got.header_complete, got.line_dropped, got.header_overflow);
            errors++;
          end
        end
      end

      // Classify the accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        len_cap = (len_limit > LenCapMax) ? LenCapMax : len_limit;
        hdr_cap = (hdr_limit > HdrCapMax) ? HdrCapMax : hdr_limit;
        want = '0;
        want.out_byte = s_axis_tdata;
        want.kind     = KIND_BODY;
        handled       = 1'b0;
        if (s_axis_tuser[0]) begin
          parse_st  = ST_LINE_START;
          line_len  = '0;
          hdr_count = '0;
        end
        want.header_index = hdr_count;
        st = parse_st;

        // Resolve the byte after a CR
        if (st == ST_AFTER_CR) begin
          if (s_axis_tdata == ChLf) begin
            want.kind = KIND_SEP;
            parse_st  = ST_LINE_START;
            handled   = 1'b1;
          end else begin
            st = ST_LINE_START;
          end
        end else if (st == ST_START_CR) begin
          if (s_axis_tdata == ChLf) begin
            want.kind = KIND_END_HDR;
            parse_st  = ST_DONE;
            handled   = 1'b1;
          end else begin
            want.line_dropped = 1'b1;
            st = ST_LINE_START;
          end
        end

        if (!handled) begin
          if (st > ST_VALUE) begin
            want.kind = KIND_BODY;
            parse_st  = ST_DONE;
          end else if (s_axis_tdata == ChNul || s_axis_tdata == ChCr) begin
            // Close a non-empty line: count it, overflow it or drop it
            if (st != ST_LINE_START) begin
              if (st == ST_SKIP_WS || st == ST_VALUE) begin
                if (hdr_count < hdr_cap) begin
                  want.header_complete = 1'b1;
                  hdr_count++;
                end else begin
                  want.header_overflow = 1'b1;
                end
              end else begin
                want.line_dropped = 1'b1;
              end
            end
            line_len = '0;
            if (s_axis_tdata == ChNul) begin
              want.kind = KIND_END_INPUT;
              parse_st  = ST_DONE;
            end else begin
              want.kind = KIND_SEP;
              parse_st  = (st == ST_LINE_START) ? ST_START_CR : ST_AFTER_CR;
            end
          end else if (line_len >= len_cap) begin
            want.kind = KIND_TOO_LONG;
            parse_st  = ST_DONE;
          end else begin
            line_len++;
            if (st == ST_LINE_START || st == ST_NAME) begin
              if (s_axis_tdata == ChColon) begin
                want.kind = KIND_SEP;
                parse_st  = ST_SKIP_WS;
              end else begin
                want.kind = KIND_NAME;
                parse_st  = ST_NAME;
              end
            end else if (st == ST_SKIP_WS &&
                         (s_axis_tdata == ChSpace || s_axis_tdata == ChTab)) begin
              want.kind = KIND_SEP;
            end else begin
              want.kind = KIND_VALUE;
              parse_st  = ST_VALUE;
            end
          end
        end
        classified_q.push_back(want);
      end

      // Track register writes
      if (cfg_we) begin
        case (cfg_addr)
          RegMaxLineLength: len_limit = cfg_data;
          RegMaxHeaders:    hdr_limit = cfg_data[7:0];
          default: ;
        endcase
      end
    end
    pending_results <= classified_q.size();
    fail_count      <= errors;
  end

endmodule

@@ tb/tb_mime_header_line_splitter_core.sv @@
// ----------------------------------------------------------------------------
// tb_mime_header_line_splitter_core
// Drives header text through the splitter: directed lines for each parser
// corner, then random header blocks and noise under several limit settings,
// with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_mime_header_line_splitter_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mhls_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 400;
  localparam int PhaseItems    = 90;
  localparam int NumPhases     = 7;
  localparam int LongLineLimit = 300;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_addr;
  logic [11:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser;   // [0] start_block
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] out_byte, [15:8] header_index,
                               // [16] header_complete, [17] line_dropped,
                               // [18] header_overflow, [23:19] zero
  logic [2:0]  m_axis_tuser;   // [2:0] kind

  int pending_results;
  int fail_count;
  int items_sent;
  int idle_cycles;
  int cur_len;
  int cur_hdr;
  bit open_block;
  bit calm;
  bit squeeze_done;

  mime_header_line_splitter_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  mhls_stream_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .pending_results (pending_results),
    .fail_count      (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Header text byte; never CR or NUL, no colon in a name
  function automatic logic [7:0] text_byte(input bit in_value);
    logic [7:0] b;
    case ($urandom_range(0, 15))
      0:       b = 8'($urandom_range(1, 255));
      1:       b = ChLf;
      2:       b = ChSpace;
      3:       b = ChTab;
      default: b = 8'($urandom_range(8'h41, 8'h7A));
    endcase
    if (b == ChCr || (!in_value && b == ChColon)) b = 8'h5F;
    return b;
  endfunction

  // Offer one request and hold it until accepted; enter and leave at negedge
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = open_block;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    open_block = 1'b0;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Drain the block, then program both limits
  task automatic write_limits(input int len, input int hdr);
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = RegMaxLineLength;
    cfg_data = 12'(len);
    @(negedge clk);
    cfg_addr = RegMaxHeaders;
    cfg_data = 12'(hdr & 255);
    @(negedge clk);
    cfg_we  = 1'b0;
    cur_len = len;
    cur_hdr = (hdr > 128) ? 128 : hdr;
  endtask

  task automatic emit_line();
    int  n_name;
    int  n_ws;
    int  n_val;
    bit  no_colon;
    no_colon = ($urandom_range(0, 9) == 0);
    n_name   = $urandom_range(no_colon ? 1 : 0, 6);
    n_ws     = $urandom_range(0, 2);
    n_val    = $urandom_range(0, 8);
    // Aim some lines right at the length limit
    if (cur_len <= 64 && $urandom_range(0, 7) == 0)
      n_name = $urandom_range((cur_len > 0) ? cur_len - 1 : 0, cur_len + 1);
    repeat (n_name) push_byte(text_byte(1'b0));
    if (!no_colon) begin
      push_byte(ChColon);
      repeat (n_ws) push_byte($urandom_range(0, 1) ? ChSpace : ChTab);
      repeat (n_val) push_byte(text_byte(1'b1));
    end
    push_byte(ChCr);
    if ($urandom_range(0, 9) < 8) push_byte(ChLf);
  endtask

  task automatic emit_block();
    int lines;
    int r;
    open_block = 1'b1;
    lines = $urandom_range(0, (cur_hdr < 6) ? cur_hdr + 2 : 6);
    repeat (lines) emit_line();
    r = $urandom_range(0, 9);
    if (r < 7) begin
      push_byte(ChCr);
      push_byte(ChLf);
    end else if (r < 9) begin
      push_byte(ChNul);
    end
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic emit_noise();
    repeat ($urandom_range(1, 10)) begin
      open_block = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 7))
        0:       push_byte(ChCr);
        1:       push_byte(ChLf);
        2:       push_byte(ChColon);
        3:       push_byte(ChNul);
        default: push_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Output side: random stalls plus one long hold-off to back up the input
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    squeeze_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeeze_done && items_sent >= 200) begin
        squeeze_done  = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int len_plan [NumPhases];
    int hdr_plan [NumPhases];
    int p;
    int start;
    len_plan      = '{4095, 1, 6, 12, 30, 4095, 0};
    hdr_plan      = '{128, 1, 3, 5, 128, 2, 0};
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = RegMaxLineLength;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    items_sent    = 0;
    cur_len       = 4095;
    cur_hdr       = 128;
    open_block    = 1'b0;
    calm          = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed corners at reset limits: bare LF in a name, skipped blanks,
    // colon in a value, dropped lines, CR without LF, CR at line start,
    // end of headers, NUL inside and at start of a line, high bytes
    open_block = 1'b1;
    push_text("\012: \tv:\015\012");
    push_text("n\015k:\015\015q\015\012\015\012x");
    push_byte(ChNul);
    open_block = 1'b1;
    push_text("a:");
    push_byte(ChNul);
    open_block = 1'b1;
    push_byte(ChNul);
    open_block = 1'b1;
    push_byte(ChCr);
    push_byte(ChNul);
    open_block = 1'b1;
    push_byte(8'hFF);

    // Zero limits abort at once; header limit zero overflows
    write_limits(0, 0);
    open_block = 1'b1;
    push_text(":");
    write_limits(2, 0);
    open_block = 1'b1;
    push_text(":\015\012abc");
    write_limits(4095, 1);
    open_block = 1'b1;
    push_text(":\015\012:\015\012");

    // Random header blocks under several limits
    for (p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1)
        write_limits($urandom_range(1, 64), $urandom_range(1, 128));
      else
        write_limits(len_plan[p], hdr_plan[p]);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        calm = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0) emit_noise();
        else emit_block();
      end
    end
    calm = 1'b0;

    // Wide limits: a line right up to its limit, then fill every header slot
    // and overflow
    write_limits(LongLineLimit, 255);
    open_block = 1'b1;
    repeat (LongLineLimit) push_byte(8'h78);
    push_byte(8'h79);
    open_block = 1'b1;
    repeat (130) push_text(":\015\012");
    push_text("\015\012");

    // Drain and report
    s_axis_tvalid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ mime_header_line_splitter_core.f @@
rtl/core/mhls_pkg.sv
rtl/core/mhls_parse.sv
rtl/core/mime_header_line_splitter_core.sv
rtl/core/mhls_checker.sv
tb/mhls_stream_checker.sv
tb/tb_mime_header_line_splitter_core.sv
